// ----- rtl/modular_exponentiation_macros.svh -----
`ifndef MODULAR_EXPONENTIATION_MACROS_SVH
`define MODULAR_EXPONENTIATION_MACROS_SVH

// clocked assertion, quiet while reset is high
`define MEXP_ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds through reset
`define MEXP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/mexp_pkg.sv -----
package mexp_pkg;

  localparam int OPERAND_BITS = 63;
  localparam int FIELD_BITS = 63;
  localparam int CNT_BITS = $clog2(OPERAND_BITS);

  localparam int BASE_LSB = 0;
  localparam int EXP_LSB = FIELD_BITS;
  localparam int MOD_LSB = 2 * FIELD_BITS;

  localparam int IN_DATA_BITS = ((3 * FIELD_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS = ((FIELD_BITS + 7) / 8) * 8;
  localparam int OUT_USER_BITS = 1;

  typedef logic [OPERAND_BITS-1:0] operand_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RED_GO,
    ST_RED_WAIT,
    ST_STEP_GO,
    ST_STEP_WAIT,
    ST_DONE
  } mexp_state_t;

endpackage

// ----- rtl/modular_exponentiation.sv -----
// modular exponentiation, right-to-left square and multiply
// input channel s_*: one beat carries base, exponent and modulus; s_tready is
//   high only while the block is idle, so one item is in flight at a time
// output channel m_*: one beat per item with the power and the bad modulus flag
// zero modulus: result 0 with the flag set, in the cycle after the input beat
// zero exponent: result 1, in the cycle after the input beat
// otherwise the base is first reduced, then each exponent bit up to the highest
//   set one runs a square and a multiply side by side in two bit-serial
//   modular multipliers
// after the result beat the block returns to idle, where it takes the next input beat
// a stalled receiver holds the result beat; no new input is taken until it goes
// synchronous reset drops any item in flight and returns to idle
module modular_exponentiation (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // base_value, exponent, modulus, zero fill
  input  logic [mexp_pkg::IN_DATA_BITS-1:0]    s_tdata,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // power_result, zero fill
  output logic [mexp_pkg::OUT_DATA_BITS-1:0]   m_tdata,
  // bad_modulus
  output logic [mexp_pkg::OUT_USER_BITS-1:0]   m_tuser
);
  import mexp_pkg::*;

  mexp_state_t state;
  mexp_state_t state_next;

  operand_t base;
  operand_t ex;
  operand_t modv;
  operand_t acc;
  logic     bad;

  operand_t in_base;
  operand_t in_exp;
  operand_t in_mod;

  logic     start0;
  logic     start1;
  operand_t a0;
  logic     done0;
  logic     done1;
  operand_t r0;
  operand_t r1;

  assign in_base = s_tdata[BASE_LSB +: OPERAND_BITS];
  assign in_exp  = s_tdata[EXP_LSB +: OPERAND_BITS];
  assign in_mod  = s_tdata[MOD_LSB +: OPERAND_BITS];

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          if (in_mod == '0 || in_exp == '0) begin
            state_next = ST_DONE;
          end else begin
            state_next = ST_RED_GO;
          end
        end
      end
      ST_RED_GO:   state_next = ST_RED_WAIT;
      ST_RED_WAIT: begin
        if (done0) begin
          state_next = ST_STEP_GO;
        end
      end
      ST_STEP_GO:  state_next = ST_STEP_WAIT;
      ST_STEP_WAIT: begin
        if (done0) begin
          state_next = ((ex >> 1) == '0) ? ST_DONE : ST_STEP_GO;
        end
      end
      ST_DONE: begin
        if (m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready = (state == ST_IDLE);
    m_tvalid = (state == ST_DONE);
    start0 = (state == ST_RED_GO) || (state == ST_STEP_GO);
    start1 = (state == ST_STEP_GO);
    // base reduction runs as 1 * base mod m
    a0 = (state == ST_RED_GO) ? OPERAND_BITS'(1) : acc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          base <= in_base;
          ex <= in_exp;
          modv <= in_mod;
          bad <= (in_mod == '0);
          acc <= (in_mod == '0) ? '0 : OPERAND_BITS'(1);
        end
      end
      ST_RED_WAIT: begin
        if (done0) begin
          base <= r0;
          acc <= (modv == OPERAND_BITS'(1)) ? '0 : OPERAND_BITS'(1);
        end
      end
      ST_STEP_WAIT: begin
        if (done0) begin
          if (ex[0]) begin
            acc <= r0;
          end
          base <= r1;
          ex <= ex >> 1;
        end
      end
      default: begin
      end
    endcase
  end

  mexp_mulmod u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (start0),
    .a      (a0),
    .b      (base),
    .m      (modv),
    .done   (done0),
    .result (r0)
  );

  mexp_mulmod u_sqr (
    .clk    (clk),
    .rst    (rst),
    .start  (start1),
    .a      (base),
    .b      (base),
    .m      (modv),
    .done   (done1),
    .result (r1)
  );

  assign m_tdata = OUT_DATA_BITS'(acc);
  assign m_tuser = OUT_USER_BITS'(bad);

endmodule

// ----- rtl/mexp_mulmod.sv -----
module mexp_mulmod (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  mexp_pkg::operand_t  a,
  input  mexp_pkg::operand_t  b,
  input  mexp_pkg::operand_t  m,
  output logic                done,
  output mexp_pkg::operand_t  result
);
  import mexp_pkg::*;

  logic                  busy;
  logic                  phase;
  logic [CNT_BITS-1:0]   cnt;
  operand_t              acc;
  operand_t              opa;
  operand_t              opb;
  operand_t              opm;

  logic [OPERAND_BITS:0]   sum;
  logic [OPERAND_BITS+1:0] diff;
  operand_t                acc_next;

  // phase 0 doubles, phase 1 adds a when the current bit of b is set
  always_comb begin
    if (!phase) begin
      sum = {acc, 1'b0};
    end else begin
      sum = {1'b0, acc} + {1'b0, (opb[OPERAND_BITS-1] ? opa : '0)};
    end
    diff = {1'b0, sum} - {2'b00, opm};
    acc_next = diff[OPERAND_BITS+1] ? sum[OPERAND_BITS-1:0] : diff[OPERAND_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      phase <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        phase <= 1'b0;
      end else if (busy) begin
        phase <= ~phase;
        if (phase && cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= '0;
      opa <= a;
      opb <= b;
      opm <= m;
      cnt <= CNT_BITS'(OPERAND_BITS - 1);
    end else if (busy) begin
      acc <= acc_next;
      if (phase) begin
        opb <= {opb[OPERAND_BITS-2:0], 1'b0};
        cnt <= cnt - 1'b1;
      end
    end
  end

  assign result = acc;

endmodule

// ----- rtl/mexp_checker.sv -----
`include "modular_exponentiation_macros.svh"

module mexp_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 s_tvalid,
  input logic                                 s_tready,
  input logic [mexp_pkg::IN_DATA_BITS-1:0]    s_tdata,
  input logic                                 m_tvalid,
  input logic                                 m_tready,
  input logic [mexp_pkg::OUT_DATA_BITS-1:0]   m_tdata,
  input logic [mexp_pkg::OUT_USER_BITS-1:0]   m_tuser
);
  import mexp_pkg::*;

  logic in_beat;
  logic mod_zero;
  logic exp_zero;

  assign in_beat  = s_tvalid && s_tready;
  assign mod_zero = (s_tdata[MOD_LSB +: OPERAND_BITS] == '0);
  assign exp_zero = (s_tdata[EXP_LSB +: OPERAND_BITS] == '0);

  `MEXP_ASSERT_CLK(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result beat changed while stalled")
  `MEXP_ASSERT_ALWAYS(a_one_in_flight, m_tvalid |-> !s_tready, "input taken while a result waits")
  `MEXP_ASSERT_CLK(a_bad_mod, in_beat && mod_zero |=> m_tvalid && m_tuser[0] && m_tdata == '0, "zero modulus not flagged")
  `MEXP_ASSERT_CLK(a_zero_exp, in_beat && !mod_zero && exp_zero |=> m_tvalid && !m_tuser[0] && m_tdata == OUT_DATA_BITS'(1), "zero exponent does not give one")

endmodule

bind modular_exponentiation mexp_checker u_mexp_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
